@@ hdl/fcst_pkg.sv @@
// Package for the fixed-capacity set table: capacity, widths, operation codes
// and the transaction structs. No dependencies.
package fcst_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic             changed;
    logic             refused_full;
    logic [OCC_W-1:0] occupancy;
    logic             empty_flag;
    logic             full_flag;
  } out_t;

  typedef struct packed {
    logic occupied;
    logic append;
    logic remove;
  } cell_ctl_t;

endpackage

@@ hdl/fixed_capacity_set_table.sv @@
// Fixed-capacity set table: a row of fcst_cell slots with an occupancy count.
// Result: registered on the clock edge that accepts the input transaction.
// Throughput: one operation per cycle while out_ready keeps up; all slots compare
// in parallel and the delete shift moves every later slot down one place in the same cycle.
// Reset: synchronous active-low rst_n clears the count and the result valid;
// slot contents are not reset. Uses fcst_pkg and fcst_cell.
module fixed_capacity_set_table (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fcst_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fcst_pkg::out_t  out_data
);
  import fcst_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  out_t                    out_data_r;
  out_t                    res;

  logic                    accept;
  logic                    is_ins;
  logic                    is_del;
  logic                    full;
  logic                    hit;
  logic                    do_append;
  logic                    do_remove;

  logic [CAPACITY:0]       seen;
  cell_ctl_t               ctl   [CAPACITY];
  logic signed [VAL_W-1:0] entry [CAPACITY];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_ins    = (func_t'(in_data.func) == FUNC_INSERT);
  assign is_del    = (func_t'(in_data.func) == FUNC_DELETE);
  assign full      = (count_r >= CNT_W'(CAPACITY));
  assign seen[0]   = 1'b0;
  assign hit       = seen[CAPACITY];
  assign do_append = accept && is_ins && !full && !hit;
  assign do_remove = accept && is_del && hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i].occupied = (CNT_W'(i) < count_r);
    assign ctl[i].append   = do_append && (count_r == CNT_W'(i));
    assign ctl[i].remove   = do_remove;

    fcst_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .key       (in_data.value),
      .nbr_entry (entry[(i + 1 < CAPACITY) ? i + 1 : i]),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .entry     (entry[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
    res.hit          = hit;
    res.changed      = do_append || do_remove;
    res.refused_full = is_ins && full;
    res.occupancy    = OCC_W'(count_nxt);
    res.empty_flag   = (count_nxt == '0);
    res.full_flag    = (count_nxt == CNT_W'(CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/fcst_cell.sv @@
// One slot of the set table: holds an entry, compares it to the key, passes
// the match chain on and, at or past a match, takes its upper neighbor's entry on delete. Uses fcst_pkg.
module fcst_cell (
  input  logic                            clk,
  input  fcst_pkg::cell_ctl_t             ctl,
  input  logic signed [fcst_pkg::VAL_W-1:0] key,
  input  logic signed [fcst_pkg::VAL_W-1:0] nbr_entry,
  input  logic                            seen_in,
  output logic                            seen_out,
  output logic signed [fcst_pkg::VAL_W-1:0] entry
);
  import fcst_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    match;

  assign match    = ctl.occupied && (entry_r == key);
  assign seen_out = seen_in | match;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.append) begin
      entry_nxt = key;
    end else if (ctl.remove && seen_out) begin
      entry_nxt = nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
